// ===== sv/somr_pkg.sv =====
// Shared types and constants for the spiral-order matrix reader.
`timescale 1ns / 1ps
package somr_pkg;

  localparam int DATA_W       = 32;
  localparam int CFG_W        = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 4'd8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // take one word into the store
    logic step;   // issue one spiral read and advance the walk
  } somr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic load_full;  // the word being loaded completes the matrix
    logic walk_last;  // the read being issued is the last of the spiral
  } somr_sts_t;

endpackage

// ===== sv/somr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module somr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/somr_ctrl.sv =====
// Controller: load / emit sequencing for the spiral-order matrix reader.
`timescale 1ns / 1ps
module somr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output somr_pkg::somr_cmd_t cmd,
  input  somr_pkg::somr_sts_t sts
);
  import somr_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign busy     = (state_r == S_EMIT);
  assign cmd.load = start && !busy;
  assign cmd.step = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (cmd.load && sts.load_full) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.walk_last) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/somr_dp.sv =====
// Datapath: size registers, load counter, matrix store and spiral walker.
`timescale 1ns / 1ps
module somr_dp #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  somr_pkg::somr_cmd_t                 cmd,
  output somr_pkg::somr_sts_t                 sts,
  input  logic                                cfg_we,
  input  logic [somr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [somr_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic signed [somr_pkg::DATA_W-1:0]  in_element_value,
  output logic signed [somr_pkg::DATA_W-1:0]  out_element_value_out,
  output logic                                out_valid,
  output logic                                out_last_of_run
);
  import somr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int TW    = RW + CW;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  // Size registers
  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [RW-1:0]    rows;
  logic [CW-1:0]    cols;
  logic [TW-1:0]    total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_SIZE_RST;
      cols_cfg_r <= CFG_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    rows_cfg_r <= cfg_wdata;
        REG_COLUMN_COUNT: cols_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows = RW'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols = CW'(1);
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(cols_cfg_r);
    end
  end

  assign total = TW'(rows) * TW'(cols);

  // Load counter
  logic [CNTW-1:0] load_cnt_r, load_cnt_nxt;
  logic [CNTW:0]   load_inc;
  logic            st_we;

  assign load_inc      = {1'b0, load_cnt_r} + 1'b1;
  assign sts.load_full = (load_inc >= (CNTW + 1)'(total));
  assign st_we         = cmd.load && (int'(load_cnt_r) < DEPTH);

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (cmd.load) begin
      load_cnt_nxt = sts.load_full ? '0 : load_inc[CNTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

  // Spiral walker: current position plus the four shrinking bounds
  logic [RW-1:0]   row_r, row_nxt, top_r, top_nxt, bot_r, bot_nxt;
  logic [CW-1:0]   col_r, col_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;
  dir_t            dir_r, dir_nxt;
  logic [CNTW-1:0] emit_cnt_r, emit_cnt_nxt;
  logic [CNTW:0]   emit_inc;
  logic [TW-1:0]   lin_addr;

  assign emit_inc      = {1'b0, emit_cnt_r} + 1'b1;
  assign sts.walk_last = (emit_inc == (CNTW + 1)'(total));
  assign lin_addr      = TW'(row_r) * TW'(cols) + TW'(col_r);

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    lft_nxt      = lft_r;
    rgt_nxt      = rgt_r;
    dir_nxt      = dir_r;
    emit_cnt_nxt = emit_cnt_r;
    if (cmd.load && sts.load_full) begin
      row_nxt      = '0;
      col_nxt      = '0;
      top_nxt      = '0;
      bot_nxt      = rows - 1'b1;
      lft_nxt      = '0;
      rgt_nxt      = cols - 1'b1;
      dir_nxt      = DIR_RIGHT;
      emit_cnt_nxt = '0;
    end else if (cmd.step) begin
      emit_cnt_nxt = emit_inc[CNTW-1:0];
      case (dir_r)
        DIR_RIGHT: begin
          if (col_r == rgt_r) begin
            top_nxt = top_r + 1'b1;
            row_nxt = top_r + 1'b1;
            dir_nxt = DIR_DOWN;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        DIR_DOWN: begin
          if (row_r == bot_r) begin
            rgt_nxt = rgt_r - 1'b1;
            col_nxt = rgt_r - 1'b1;
            dir_nxt = DIR_LEFT;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
        DIR_LEFT: begin
          if (col_r == lft_r) begin
            bot_nxt = bot_r - 1'b1;
            row_nxt = bot_r - 1'b1;
            dir_nxt = DIR_UP;
          end else begin
            col_nxt = col_r - 1'b1;
          end
        end
        default: begin
          if (row_r == top_r) begin
            lft_nxt = lft_r + 1'b1;
            col_nxt = lft_r + 1'b1;
            dir_nxt = DIR_RIGHT;
          end else begin
            row_nxt = row_r - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    lft_r      <= lft_nxt;
    rgt_r      <= rgt_nxt;
    dir_r      <= dir_nxt;
    emit_cnt_r <= emit_cnt_nxt;
  end

  // Store; read data lands together with the strobe
  logic [DATA_W-1:0] rd_data;

  somr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (in_element_value),
    .re    (cmd.step),
    .raddr (lin_addr[AW-1:0]),
    .rdata (rd_data)
  );

  logic out_valid_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.step;
      out_last_r  <= cmd.step && sts.walk_last;
    end
  end

  assign out_element_value_out = signed'(rd_data);
  assign out_valid             = out_valid_r;
  assign out_last_of_run       = out_last_r;

endmodule

// ===== sv/spiral_order_matrix_reader_top.sv =====
// Top level of the spiral-order matrix reader.
`timescale 1ns / 1ps
// Loads a rows x columns matrix one word per cycle in row-major order (start
// while busy is low), then plays it back in clockwise spiral order from the
// top-left corner, one word per cycle on out_valid, last word flagged by
// out_last_of_run. A non-final load produces nothing. The edge that accepts
// the word completing the matrix raises busy; results then follow back to
// back, N = rows*columns of them, each read registered in the store and
// strobed from the output registers, and busy drops as the last is strobed.
// Each word takes one write and one read of the single-write, single-read store.
// The receiver cannot stall; every strobe must be taken in its cycle.
// Size registers (row_count index 0, column_count index 1) reset to 8; zero
// reads as one and values above MAX_ROWS / MAX_COLS saturate. Write them only
// while the block is idle. No store clearing at reset: a spiral never reads an
// entry that was not loaded in a complete run.
module spiral_order_matrix_reader_top #(
  parameter int MAX_ROWS = somr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = somr_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               start,
  output logic                               busy,
  input  logic signed [somr_pkg::DATA_W-1:0] in_element_value,
  // results
  output logic                               out_valid,
  output logic signed [somr_pkg::DATA_W-1:0] out_element_value_out,
  output logic                               out_last_of_run,
  // configuration
  input  logic                               cfg_we,
  input  logic [somr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [somr_pkg::CFG_W-1:0]         cfg_wdata
);
  import somr_pkg::*;

  somr_cmd_t cmd;
  somr_sts_t sts;

  // FSM: decides when to load and when to walk
  somr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Store, counters and spiral address generation
  somr_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_element_value      (in_element_value),
    .out_element_value_out (out_element_value_out),
    .out_valid             (out_valid),
    .out_last_of_run       (out_last_of_run)
  );

  // A result always comes from a read issued while busy
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding read");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_of_run |-> out_valid)
    else $error("last flag without strobe");

  // A non-final result means the walk is still running
  a_more_to_come: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> busy)
    else $error("walk stopped before the last word");

  // Playback ends only with the last word
  a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_last_of_run)
    else $error("busy dropped without a last word");

endmodule
